// File: design/top_k_prefix_autocomplete_top_macros.svh
// Assertion macros shared by the autocomplete block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef TOP_K_PREFIX_AUTOCOMPLETE_TOP_MACROS_SVH
`define TOP_K_PREFIX_AUTOCOMPLETE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TKPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TKPA_NEVER(lbl, clk, rst_n, expr, msg) \
    `TKPA_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define TKPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TKPA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/tkpa_pkg.sv
// Package for the autocomplete block: sizes, codes, state type and
// the command and status structs between controller and datapath. No dependencies.
package tkpa_pkg;

    localparam int MAX_WORDS    = 1024;
    localparam int MAX_WORD_LEN = 15;
    localparam int TOP_K        = 10;

    localparam int SYM_W      = 8;
    localparam int FREQ_W     = 20;
    localparam int WORD_ID_W  = 10;

    localparam int WID_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int LEN_W      = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_WORD_LEN);
    localparam int CHAR_DEPTH = MAX_WORDS * MAX_WORD_LEN;
    localparam int CADDR_W    = $clog2(CHAR_DEPTH);
    localparam int P_W        = $clog2(TOP_K + 1);
    localparam int KIDX_W     = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int META_W     = LEN_W + FREQ_W;

    // Request type codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSTART,
        S_WMETA,
        S_CREQ,
        S_CCAP,
        S_OFFER,
        S_CMP,
        S_TREQ,
        S_TCAP,
        S_INS,
        S_WNEXT,
        S_EMIT
    } st_t;

    typedef struct packed {
        logic ins_accept;
        logic pat_accept;
        logic scan_start;
        logic meta_rd;
        logic meta_cap;
        logic chr_rd;
        logic chr_cap;
        logic offer_start;
        logic p_dec;
        logic tie_start;
        logic tie_rd;
        logic i_inc;
        logic ins_do;
        logic w_next;
        logic emit_start;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic w_done;
        logic len_short;
        logic load_done;
        logic chr_mis;
        logic p_zero;
        logic freq_gt;
        logic freq_lt;
        logic tie_done;
        logic len_lt;
        logic chr_lt;
        logic chr_gt;
        logic emit_last;
    } sts_t;

endpackage

// File: design/tkpa_req_if.sv
// Request channel interface: one character of a word or pattern per transaction.
// Depends on tkpa_pkg.
interface tkpa_req_if import tkpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    logic [FREQ_W-1:0] frequency;

    modport source (output valid, req_type, symbol, last, frequency, input ready);
    modport sink   (input valid, req_type, symbol, last, frequency, output ready);
endinterface

// File: design/tkpa_rsp_if.sv
// Response channel interface: one ranked word id per transaction.
// Depends on tkpa_pkg.
interface tkpa_rsp_if import tkpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_ID_W-1:0] word_id;
    logic                 found;
    logic                 end_of_list;

    modport source (output valid, word_id, found, end_of_list, input ready);
    modport sink   (input valid, word_id, found, end_of_list, output ready);
endinterface

// File: design/tkpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: design/tkpa_ctrl.sv
// Controller state machine: handshakes, word scan, ranking and result sequencing.
// Depends on tkpa_pkg.
module tkpa_ctrl import tkpa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_req_type,
    input  logic in_last,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    st_t state_reg;
    st_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_req_type == REQ_QUERY && in_last)
                begin
                    state_next = S_WSTART;
                end
            end
            S_WSTART:
            begin
                state_next = sts.w_done ? S_EMIT : S_WMETA;
            end
            S_WMETA:
            begin
                state_next = sts.len_short ? S_WNEXT : S_CREQ;
            end
            S_CREQ:
            begin
                state_next = sts.load_done ? S_OFFER : S_CCAP;
            end
            S_CCAP:
            begin
                state_next = sts.chr_mis ? S_WNEXT : S_CREQ;
            end
            S_OFFER:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (sts.p_zero)
                begin
                    state_next = S_INS;
                end
                else if (sts.freq_gt)
                begin
                    state_next = S_CMP;
                end
                else if (sts.freq_lt)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_TREQ;
                end
            end
            S_TREQ:
            begin
                priority if (!sts.tie_done)
                begin
                    state_next = S_TCAP;
                end
                else if (sts.len_lt)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_TCAP:
            begin
                priority if (sts.chr_lt)
                begin
                    state_next = S_CMP;
                end
                else if (sts.chr_gt)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_TREQ;
                end
            end
            S_INS:
            begin
                state_next = S_WNEXT;
            end
            S_WNEXT:
            begin
                state_next = S_WSTART;
            end
            S_EMIT:
            begin
                if (out_ready && sts.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == REQ_INSERT)
                    begin
                        cmd.ins_accept = 1'b1;
                    end
                    else
                    begin
                        cmd.pat_accept = 1'b1;
                        cmd.scan_start = in_last;
                    end
                end
            end
            S_WSTART:
            begin
                cmd.emit_start = sts.w_done;
                cmd.meta_rd    = !sts.w_done;
            end
            S_WMETA:
            begin
                cmd.meta_cap = 1'b1;
            end
            S_CREQ:
            begin
                cmd.chr_rd = !sts.load_done;
            end
            S_CCAP:
            begin
                cmd.chr_cap = !sts.chr_mis;
            end
            S_OFFER:
            begin
                cmd.offer_start = 1'b1;
            end
            S_CMP:
            begin
                cmd.p_dec     = !sts.p_zero && sts.freq_gt;
                cmd.tie_start = !sts.p_zero && !sts.freq_gt && !sts.freq_lt;
            end
            S_TREQ:
            begin
                cmd.tie_rd = !sts.tie_done;
                cmd.p_dec  = sts.tie_done && sts.len_lt;
            end
            S_TCAP:
            begin
                cmd.p_dec = sts.chr_lt;
                cmd.i_inc = !sts.chr_lt && !sts.chr_gt;
            end
            S_INS:
            begin
                cmd.ins_do = 1'b1;
            end
            S_WNEXT:
            begin
                cmd.w_next = 1'b1;
            end
            S_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.emit_next = out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// File: design/tkpa_dp.sv
// Datapath: word store, pattern buffer, candidate buffer, ranked best list.
// Depends on tkpa_pkg and tkpa_ram.
module tkpa_dp import tkpa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 last,
    input  logic [FREQ_W-1:0]    frequency,
    output logic [WORD_ID_W-1:0] word_id,
    output logic                 found,
    output logic                 end_of_list
);
    // Control registers.
    logic [CNT_W-1:0]   word_count_reg, word_count_next;
    logic [LEN_W-1:0]   ins_len_reg, ins_len_next;
    logic [CADDR_W-1:0] ins_base_reg, ins_base_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [CADDR_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]   i_reg, i_next;
    logic [P_W-1:0]     p_reg, p_next;
    logic [P_W-1:0]     count_reg, count_next;
    logic [KIDX_W-1:0]  k_reg, k_next;

    // Payload registers.
    logic [SYM_W-1:0]   pat_reg [MAX_WORD_LEN];
    logic [SYM_W-1:0]   pat_next [MAX_WORD_LEN];
    logic [SYM_W-1:0]   cand_reg [MAX_WORD_LEN];
    logic [SYM_W-1:0]   cand_next [MAX_WORD_LEN];
    logic [LEN_W-1:0]   cand_len_reg, cand_len_next;
    logic [FREQ_W-1:0]  cand_freq_reg, cand_freq_next;
    logic [WID_W-1:0]   best_id_reg [TOP_K];
    logic [WID_W-1:0]   best_id_next [TOP_K];
    logic [FREQ_W-1:0]  best_freq_reg [TOP_K];
    logic [FREQ_W-1:0]  best_freq_next [TOP_K];
    logic [LEN_W-1:0]   best_len_reg [TOP_K];
    logic [LEN_W-1:0]   best_len_next [TOP_K];
    logic [CADDR_W-1:0] best_base_reg [TOP_K];
    logic [CADDR_W-1:0] best_base_next [TOP_K];

    // Memory ports and helpers.
    logic               room;
    logic               ins_len_ok;
    logic [LEN_W-1:0]   ins_len_inc;
    logic               chr_wr_en;
    logic [CADDR_W-1:0] chr_wr_addr;
    logic               chr_rd_en;
    logic [CADDR_W-1:0] chr_rd_addr;
    logic [SYM_W-1:0]   chr_rd_data;
    logic               meta_wr_en;
    logic [META_W-1:0]  meta_rd_data;
    logic [LEN_W-1:0]   meta_len;
    logic [FREQ_W-1:0]  meta_freq;
    logic [P_W-1:0]     p_m1;
    logic [KIDX_W-1:0]  pidx;
    logic [LEN_W-1:0]   min_len;
    logic [IDX_W-1:0]   ii;
    logic [31:0]        id_wide;

    assign room        = word_count_reg < CNT_W'(MAX_WORDS);
    assign ins_len_ok  = ins_len_reg < LEN_W'(MAX_WORD_LEN);
    assign ins_len_inc = ins_len_ok ? ins_len_reg + 1'b1 : ins_len_reg;
    assign chr_wr_en   = cmd.ins_accept && room && ins_len_ok;
    assign chr_wr_addr = ins_base_reg + CADDR_W'(ins_len_reg);
    assign meta_wr_en  = cmd.ins_accept && last && room;
    assign p_m1        = p_reg - 1'b1;
    assign pidx        = p_m1[KIDX_W-1:0];
    assign ii          = i_reg[IDX_W-1:0];
    assign chr_rd_en   = cmd.chr_rd || cmd.tie_rd;
    assign chr_rd_addr = cmd.chr_rd ? base_reg + CADDR_W'(i_reg)
                                    : best_base_reg[pidx] + CADDR_W'(i_reg);
    assign meta_len    = meta_rd_data[META_W-1:FREQ_W];
    assign meta_freq   = meta_rd_data[FREQ_W-1:0];
    assign min_len     = (cand_len_reg < best_len_reg[pidx]) ? cand_len_reg
                                                             : best_len_reg[pidx];

    tkpa_ram #(.WIDTH(SYM_W), .DEPTH(CHAR_DEPTH)) u_chars (
        .clk     (clk),
        .wr_en   (chr_wr_en),
        .wr_addr (chr_wr_addr),
        .wr_data (symbol),
        .rd_en   (chr_rd_en),
        .rd_addr (chr_rd_addr),
        .rd_data (chr_rd_data)
    );

    tkpa_ram #(.WIDTH(META_W), .DEPTH(MAX_WORDS)) u_meta (
        .clk     (clk),
        .wr_en   (meta_wr_en),
        .wr_addr (word_count_reg[WID_W-1:0]),
        .wr_data ({ins_len_inc, frequency}),
        .rd_en   (cmd.meta_rd),
        .rd_addr (w_reg[WID_W-1:0]),
        .rd_data (meta_rd_data)
    );

    // Status back to the controller.
    always_comb
    begin
        sts.w_done    = w_reg == word_count_reg;
        sts.len_short = meta_len < plen_reg;
        sts.load_done = i_reg == cand_len_reg;
        sts.chr_mis   = (i_reg < plen_reg) && (chr_rd_data != pat_reg[ii]);
        sts.p_zero    = p_reg == '0;
        sts.freq_gt   = cand_freq_reg > best_freq_reg[pidx];
        sts.freq_lt   = cand_freq_reg < best_freq_reg[pidx];
        sts.tie_done  = i_reg == min_len;
        sts.len_lt    = cand_len_reg < best_len_reg[pidx];
        sts.chr_lt    = cand_reg[ii] < chr_rd_data;
        sts.chr_gt    = cand_reg[ii] > chr_rd_data;
        sts.emit_last = (count_reg == '0) || (P_W'(k_reg) + 1'b1 == count_reg);
    end

    // Next values.
    always_comb
    begin
        word_count_next = word_count_reg;
        ins_len_next    = ins_len_reg;
        ins_base_next   = ins_base_reg;
        plen_next       = plen_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pat_next        = pat_reg;
        cand_next       = cand_reg;
        cand_len_next   = cand_len_reg;
        cand_freq_next  = cand_freq_reg;
        best_id_next    = best_id_reg;
        best_freq_next  = best_freq_reg;
        best_len_next   = best_len_reg;
        best_base_next  = best_base_reg;

        // Dictionary insert.
        if (cmd.ins_accept)
        begin
            ins_len_next = ins_len_inc;
            if (last)
            begin
                ins_len_next = '0;
                if (room)
                begin
                    word_count_next = word_count_reg + 1'b1;
                    ins_base_next   = ins_base_reg + CADDR_W'(MAX_WORD_LEN);
                end
            end
        end

        // Pattern capture.
        if (cmd.pat_accept && plen_reg < LEN_W'(MAX_WORD_LEN))
        begin
            pat_next[plen_reg[IDX_W-1:0]] = symbol;
            plen_next = plen_reg + 1'b1;
        end

        if (cmd.scan_start)
        begin
            w_next     = '0;
            base_next  = '0;
            count_next = '0;
        end

        // Candidate loading.
        if (cmd.meta_cap)
        begin
            cand_len_next  = meta_len;
            cand_freq_next = meta_freq;
            i_next         = '0;
        end
        if (cmd.chr_cap)
        begin
            cand_next[ii] = chr_rd_data;
            i_next        = i_reg + 1'b1;
        end

        // Ranking against the best list.
        if (cmd.offer_start)
        begin
            p_next = count_reg;
        end
        if (cmd.p_dec)
        begin
            p_next = p_m1;
        end
        if (cmd.tie_start)
        begin
            i_next = '0;
        end
        if (cmd.i_inc)
        begin
            i_next = i_reg + 1'b1;
        end

        // Insert the candidate at rank p, pushing lower ranks down.
        if (cmd.ins_do && p_reg < P_W'(TOP_K))
        begin
            for (int j = 0; j < TOP_K; j++)
            begin
                if (P_W'(j) == p_reg)
                begin
                    best_id_next[j]   = w_reg[WID_W-1:0];
                    best_freq_next[j] = cand_freq_reg;
                    best_len_next[j]  = cand_len_reg;
                    best_base_next[j] = base_reg;
                end
                else if (j > 0 && P_W'(j) > p_reg)
                begin
                    best_id_next[j]   = best_id_reg[j-1];
                    best_freq_next[j] = best_freq_reg[j-1];
                    best_len_next[j]  = best_len_reg[j-1];
                    best_base_next[j] = best_base_reg[j-1];
                end
            end
            if (count_reg < P_W'(TOP_K))
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.w_next)
        begin
            w_next    = w_reg + 1'b1;
            base_next = base_reg + CADDR_W'(MAX_WORD_LEN);
        end

        // Result sequencing.
        if (cmd.emit_start)
        begin
            k_next    = '0;
            plen_next = '0;
        end
        if (cmd.emit_next)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            ins_len_reg    <= '0;
            ins_base_reg   <= '0;
            plen_reg       <= '0;
            w_reg          <= '0;
            base_reg       <= '0;
            i_reg          <= '0;
            p_reg          <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            ins_len_reg    <= ins_len_next;
            ins_base_reg   <= ins_base_next;
            plen_reg       <= plen_next;
            w_reg          <= w_next;
            base_reg       <= base_next;
            i_reg          <= i_next;
            p_reg          <= p_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg       <= pat_next;
        cand_reg      <= cand_next;
        cand_len_reg  <= cand_len_next;
        cand_freq_reg <= cand_freq_next;
        best_id_reg   <= best_id_next;
        best_freq_reg <= best_freq_next;
        best_len_reg  <= best_len_next;
        best_base_reg <= best_base_next;
    end

    // Result fields; the empty answer carries id zero.
    assign id_wide     = 32'(best_id_reg[k_reg]);
    assign found       = count_reg != '0;
    assign word_id     = found ? id_wide[WORD_ID_W-1:0] : '0;
    assign end_of_list = sts.emit_last;
endmodule

// File: design/top_k_prefix_autocomplete_top.sv
// Channel  | Dir | Payload                               | Transaction
// req      | in  | req_type, symbol, last, frequency     | one word or pattern character
// rsp      | out | word_id, found, end_of_list           | one ranked match
//
// Insert characters and non-final pattern characters leave the block idle.
// A final pattern character starts a scan of the store. Each word has its
// metadata read and captured, is skipped if shorter than the pattern, and is
// loaded through the single character memory read port until fully read or
// a pattern mismatch drops it; a match then walks the ranked list in up to
// TOP_K + 1 steps. After the last word, results leave one per cycle while
// rsp.ready is high. No requests are taken during a scan or while results
// drain. No clearing pass after reset.
`include "top_k_prefix_autocomplete_top_macros.svh"
module top_k_prefix_autocomplete_top import tkpa_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    tkpa_req_if.sink   req,
    tkpa_rsp_if.source rsp
);
    cmd_t cmd;
    sts_t sts;

    tkpa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_last     (req.last),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    tkpa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .symbol      (req.symbol),
        .last        (req.last),
        .frequency   (req.frequency),
        .word_id     (rsp.word_id),
        .found       (rsp.found),
        .end_of_list (rsp.end_of_list)
    );

    // Requests and results are never offered in the same cycle.
    `TKPA_NEVER(a_no_overlap, clk, rst_n, req.ready && rsp.valid, "ready with results")
    // The empty answer is always the only result of its query.
    `TKPA_ASSERT(a_empty_final, clk, rst_n, (rsp.valid && !rsp.found) |-> rsp.end_of_list, "empty")
    // After the final result the block returns to taking requests.
    `TKPA_ASSERT(a_list_closes, clk, rst_n, (rsp.valid && rsp.ready && rsp.end_of_list) |=> (!rsp.valid && req.ready), "open")
endmodule

// File: sim/tb.sv
// Self-checking testbench for top_k_prefix_autocomplete_top.
// Depends on tkpa_pkg, tkpa_req_if, tkpa_rsp_if and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import tkpa_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [WORD_ID_W-1:0] word_id;
        logic                 found;
        logic                 end_of_list;
    } match_t;

    typedef struct {
        logic              req_type;
        logic [SYM_W-1:0]  symbol;
        logic              last;
        logic [FREQ_W-1:0] frequency;
        bit                typed;
        match_t            answer;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    int   idle_cycles = 0;
    bit   req_burst = 1'b0;
    bit   rsp_burst = 1'b0;

    tkpa_req_if req();
    tkpa_rsp_if rsp();

    top_k_prefix_autocomplete_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the word store and the query buffers.
    logic [SYM_W-1:0]  dict_chars [MAX_WORDS][MAX_WORD_LEN];
    int                dict_len   [MAX_WORDS];
    logic [FREQ_W-1:0] dict_freq  [MAX_WORDS];
    int                dict_count = 0;
    int                ins_len = 0;
    logic [SYM_W-1:0]  pat_chars  [MAX_WORD_LEN];
    int                pat_len = 0;

    match_t pending_matches[$];

    // True when word a outranks word b.
    function automatic bit outranks(int a, int b);
        int n;
        if (dict_freq[a] != dict_freq[b])
            return dict_freq[a] > dict_freq[b];
        n = (dict_len[a] < dict_len[b]) ? dict_len[a] : dict_len[b];
        for (int i = 0; i < n; i++)
        begin
            if (dict_chars[a][i] != dict_chars[b][i])
                return dict_chars[a][i] < dict_chars[b][i];
        end
        if (dict_len[a] != dict_len[b])
            return dict_len[a] < dict_len[b];
        return a < b;
    endfunction

    function automatic bit starts_with_pattern(int w);
        if (dict_len[w] < pat_len)
            return 1'b0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (dict_chars[w][i] != pat_chars[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one accepted character and returns the ranked matches it causes.
    function automatic void apply_char(input logic rt, input logic [SYM_W-1:0] sym,
                                       input logic lst, input logic [FREQ_W-1:0] freq,
                                       ref match_t ranked[$]);
        int best[$];
        int pos;
        ranked.delete();
        if (rt == REQ_INSERT)
        begin
            if (dict_count < MAX_WORDS && ins_len < MAX_WORD_LEN)
                dict_chars[dict_count][ins_len] = sym;
            if (ins_len < MAX_WORD_LEN)
                ins_len++;
            if (lst)
            begin
                if (dict_count < MAX_WORDS)
                begin
                    dict_len[dict_count]  = ins_len;
                    dict_freq[dict_count] = freq;
                    dict_count++;
                end
                ins_len = 0;
            end
            return;
        end
        if (pat_len < MAX_WORD_LEN)
        begin
            pat_chars[pat_len] = sym;
            pat_len++;
        end
        if (!lst)
            return;
        for (int w = 0; w < dict_count; w++)
        begin
            if (!starts_with_pattern(w))
                continue;
            if (best.size() == TOP_K && !outranks(w, best[TOP_K-1]))
                continue;
            if (best.size() == TOP_K)
                void'(best.pop_back());
            pos = best.size();
            while (pos > 0 && outranks(w, best[pos-1]))
                pos--;
            best.insert(pos, w);
        end
        pat_len = 0;
        if (best.size() == 0)
            ranked.insert(ranked.size(), '{word_id: '0, found: 1'b0, end_of_list: 1'b1});
        foreach (best[k])
            ranked.insert(ranked.size(), '{word_id: best[k][WORD_ID_W-1:0], found: 1'b1,
                                          end_of_list: (k == best.size() - 1)});
    endfunction

    // Sends one character, with a random hold-off, and records what it should produce.
    task automatic send_char(input stim_row_t row);
        match_t ranked[$];
        int gap;
        if ($urandom_range(0, 7) == 0)
            req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= row.req_type;
        req.symbol    <= row.symbol;
        req.last      <= row.last;
        req.frequency <= row.frequency;
        do
            @(posedge clk);
        while (!req.ready);
        apply_char(row.req_type, row.symbol, row.last, row.frequency, ranked);
        if (row.typed)
            pending_matches.insert(pending_matches.size(), row.answer);
        else
            foreach (ranked[k])
                pending_matches.insert(pending_matches.size(), ranked[k]);
    endtask

    task automatic send_word(input logic rt, input logic [SYM_W-1:0] chars[$],
                             input logic [FREQ_W-1:0] freq);
        stim_row_t row;
        foreach (chars[i])
        begin
            row = '{rt, chars[i], i == chars.size() - 1, freq, 1'b0, '0};
            send_char(row);
        end
    endtask

    // Mostly a small alphabet so prefixes collide; now and then any byte.
    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom_range(0, 255));
        return SYM_W'(8'h61 + $urandom_range(0, 2));
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 5))
            0: return FREQ_W'($urandom());
            1: return '1;
            default: return FREQ_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Response side: random stalls between results.
    initial
    begin
        int gap;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rsp_burst = !rsp_burst;
            gap = rsp_burst ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.word_id, rsp.found, rsp.end_of_list};
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result id=%0d found=%0b eol=%0b",
                         $time, got.word_id, got.found, got.end_of_list);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (got.word_id !== want.word_id)
                begin
                    $display("%0t: word_id expected %0d actual %0d",
                             $time, want.word_id, got.word_id);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, got.found);
                    errors++;
                end
                if (got.end_of_list !== want.end_of_list)
                begin
                    $display("%0t: end_of_list expected %0b actual %0b",
                             $time, want.end_of_list, got.end_of_list);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("top_k_prefix_autocomplete_top regression: fail");
            $finish;
        end
    end

    // Directed rows: extremes, ties, duplicates, interleaving and the empty answer.
    stim_row_t directed[] = '{
        '{REQ_QUERY,  8'h7A, 1'b1, 20'h00000, 1'b1, '{10'd0, 1'b0, 1'b1}},
        '{REQ_INSERT, 8'h61, 1'b1, 20'hFFFFF, 1'b0, '0},
        '{REQ_INSERT, 8'h61, 1'b0, 20'h00000, 1'b0, '0},
        '{REQ_INSERT, 8'h62, 1'b1, 20'h00001, 1'b0, '0},
        '{REQ_INSERT, 8'hFF, 1'b1, 20'h00000, 1'b0, '0},
        '{REQ_INSERT, 8'h00, 1'b1, 20'hFFFFF, 1'b0, '0},
        '{REQ_QUERY,  8'h61, 1'b0, 20'hFFFFF, 1'b0, '0},
        '{REQ_QUERY,  8'h62, 1'b1, 20'h00000, 1'b1, '{10'd1, 1'b1, 1'b1}},
        '{REQ_QUERY,  8'h61, 1'b1, 20'h00000, 1'b0, '0},
        '{REQ_QUERY,  8'hFF, 1'b1, 20'h00000, 1'b1, '{10'd2, 1'b1, 1'b1}},
        '{REQ_QUERY,  8'h00, 1'b1, 20'h00000, 1'b1, '{10'd3, 1'b1, 1'b1}},
        '{REQ_INSERT, 8'h63, 1'b0, 20'h00000, 1'b0, '0},
        '{REQ_QUERY,  8'h61, 1'b1, 20'h00000, 1'b0, '0},
        '{REQ_INSERT, 8'h64, 1'b1, 20'h00005, 1'b0, '0},
        '{REQ_QUERY,  8'h63, 1'b1, 20'h00000, 1'b1, '{10'd4, 1'b1, 1'b1}},
        '{REQ_INSERT, 8'h61, 1'b1, 20'hFFFFF, 1'b0, '0},
        '{REQ_QUERY,  8'h61, 1'b1, 20'h00000, 1'b0, '0},
        '{REQ_QUERY,  8'h00, 1'b1, 20'h00000, 1'b1, '{10'd3, 1'b1, 1'b1}}
    };

    initial
    begin
        logic [SYM_W-1:0] word_q[$];
        logic [SYM_W-1:0] pat_q[$];
        logic [FREQ_W-1:0] word_freq_v;
        logic [SYM_W-1:0] sym_v;
        logic last_v;
        stim_row_t row;
        int sent;
        int n;
        int wait_cycles;

        req.valid     <= 1'b0;
        req.req_type  <= REQ_INSERT;
        req.symbol    <= '0;
        req.last      <= 1'b0;
        req.frequency <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_char(directed[i]);

        // Random words and patterns, their characters interleaved at random.
        sent = 0;
        while (sent < 70)
        begin
            if (word_q.size() == 0)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 5);
                repeat (n) word_q.insert(word_q.size(), pick_symbol());
                word_freq_v = pick_freq();
            end
            if (pat_q.size() == 0)
            begin
                if ($urandom_range(0, 9) == 0 && dict_count > 0)
                begin
                    // Overlong pattern built from a stored word.
                    n = $urandom_range(0, dict_count - 1);
                    for (int i = 0; i < dict_len[n]; i++)
                        pat_q.insert(pat_q.size(), dict_chars[n][i]);
                    repeat ($urandom_range(1, 4)) pat_q.insert(pat_q.size(), pick_symbol());
                end
                else
                    repeat ($urandom_range(1, 3)) pat_q.insert(pat_q.size(), pick_symbol());
            end
            if ($urandom_range(0, 2) != 0)
            begin
                sym_v  = word_q.pop_front();
                last_v = (word_q.size() == 0);
                row = '{REQ_INSERT, sym_v, last_v, word_freq_v, 1'b0, '0};
            end
            else
            begin
                sym_v  = pat_q.pop_front();
                last_v = (pat_q.size() == 0);
                row = '{REQ_QUERY, sym_v, last_v, 20'($urandom()), 1'b0, '0};
            end
            send_char(row);
            sent++;
        end
        if (word_q.size() != 0)
            send_word(REQ_INSERT, word_q, word_freq_v);
        if (pat_q.size() != 0)
            send_word(REQ_QUERY, pat_q, '0);

        // Duplicate words at the top frequency, then a few closing queries.
        repeat (3)
        begin
            word_q = '{8'h61, 8'h62};
            send_word(REQ_INSERT, word_q, '1);
        end
        pat_q = '{8'h61};
        send_word(REQ_QUERY, pat_q, '0);
        pat_q = '{8'h63};
        send_word(REQ_QUERY, pat_q, '0);
        pat_q = '{8'h61, 8'h62};
        send_word(REQ_QUERY, pat_q, '0);
        req.valid <= 1'b0;

        // Drain, then a short settle for any stray result.
        wait_cycles = 0;
        while (pending_matches.size() != 0 && wait_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        if (errors == 0 && pending_matches.size() == 0)
            $display("top_k_prefix_autocomplete_top regression: pass");
        else
            $display("top_k_prefix_autocomplete_top regression: fail");
        $finish;
    end

endmodule
